### rtl/packet_classify_stats_assert.svh
// Assertion macros shared by the packet classifier RTL.
`ifndef PACKET_CLASSIFY_STATS_ASSERT_SVH
`define PACKET_CLASSIFY_STATS_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define PCS_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pcs: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define PCS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pcs: next-cycle check failed");

`endif

### rtl/pcs_pkg.sv
// Shared constants, types and helper functions of the packet classifier.
package pcs_pkg;

   localparam int ADDRESS_SLOTS = 64;
   localparam int SLOT_W        = (ADDRESS_SLOTS > 1) ? $clog2(ADDRESS_SLOTS) : 1;
   localparam int CNT_W         = 32;
   localparam int OUT_W         = 32;
   localparam int PORT_W        = 16;
   localparam int HIST_W        = 16;
   localparam int NUM_CAT       = 12;
   localparam int CAT_W         = 4;
   localparam int REQ_DATA_W    = 32;
   localparam int REQ_USER_W    = 2;
   localparam int RSP_DATA_W    = 96;
   localparam int RSP_USER_W    = 1;
   localparam int CSR_IDX_W     = 1;
   localparam int CSR_DATA_W    = 16;

   // Item kinds
   localparam logic [1:0] KIND_BYTE = 2'd0;
   localparam logic [1:0] KIND_CAT  = 2'd1;
   localparam logic [1:0] KIND_PORT = 2'd2;
   localparam logic [1:0] KIND_SLOT = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_WEB_A = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_WEB_B = 1'b1;
   localparam logic [PORT_W-1:0]    WEB_A_RST = 16'd80;
   localparam logic [PORT_W-1:0]    WEB_B_RST = 16'd443;

   // Category numbers
   localparam logic [CAT_W-1:0] CAT_FRAMES = 4'd0;
   localparam logic [CAT_W-1:0] CAT_BYTES  = 4'd1;
   localparam logic [CAT_W-1:0] CAT_ARP    = 4'd2;
   localparam logic [CAT_W-1:0] CAT_LLDP   = 4'd3;
   localparam logic [CAT_W-1:0] CAT_IPV4   = 4'd4;
   localparam logic [CAT_W-1:0] CAT_ICMP   = 4'd5;
   localparam logic [CAT_W-1:0] CAT_IGMP   = 4'd6;
   localparam logic [CAT_W-1:0] CAT_TCP    = 4'd7;
   localparam logic [CAT_W-1:0] CAT_UDP    = 4'd8;
   localparam logic [CAT_W-1:0] CAT_SCTP   = 4'd9;
   localparam logic [CAT_W-1:0] CAT_WEB    = 4'd10;
   localparam logic [CAT_W-1:0] CAT_DROPS  = 4'd11;

   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_ARP  = 16'h0806;
   localparam logic [15:0] ETH_LLDP = 16'h88CC;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_IGMP = 8'd2;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;
   localparam logic [7:0]  PROTO_SCTP = 8'd132;

   // Byte offsets in the frame
   localparam logic [7:0] POS_ETH_HI = 8'd12;
   localparam logic [7:0] POS_ETH_LO = 8'd13;
   localparam logic [7:0] POS_VIHL   = 8'd14;
   localparam logic [7:0] POS_PROTO  = 8'd23;
   localparam logic [7:0] POS_SRC_LO = 8'd26;
   localparam logic [7:0] POS_SRC_HI = 8'd29;
   localparam logic [7:0] POS_DST_LO = 8'd30;
   localparam logic [7:0] POS_DST_HI = 8'd33;
   localparam logic [3:0] IHL_MIN    = 4'd5;

   typedef struct packed {
      logic [15:0]     ethertype;
      logic [3:0]      ihl;
      logic [7:0]      proto;
      logic [31:0]     src_ip;
      logic [31:0]     dst_ip;
      logic [PORT_W-1:0] sport;
      logic [PORT_W-1:0] dport;
      logic            have_eth;
      logic            have_ihl;
      logic            have_proto;
      logic            have_src;
      logic            have_dst;
      logic            have_ports;
      logic [31:0]     frame_len;
   } hdr_type;

   typedef struct packed {
      logic              start;
      logic              is_src;
      logic [31:0]       key;
      logic [SLOT_W-1:0] rd_slot;
      logic              wr_en;
      logic              wr_new;
      logic [CNT_W-1:0]  wr_count;
   } tbl_cmd_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic              hit;
      logic              has_free;
      logic [CNT_W-1:0]  count;
      logic              rd_valid;
      logic [31:0]       rd_addr;
      logic [CNT_W-1:0]  rd_src;
      logic [CNT_W-1:0]  rd_dst;
   } tbl_stat_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_RD_WAIT,
      ST_FIN_FRAMES, ST_FIN_BYTES, ST_FIN_ETH, ST_FIN_PROTO, ST_FIN_WEB,
      ST_SRC_GO, ST_SRC_WAIT, ST_SRC_UPD,
      ST_DST_GO, ST_DST_WAIT, ST_DST_UPD,
      ST_HIST_RD, ST_HIST_SRC, ST_HIST_DST, ST_FIN_END
   } st_type;

   typedef enum logic {T_IDLE, T_SCAN} tbl_st_type;

   // Saturating add of two counter values
   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
   endfunction

   // Clip a 32-bit value into counter width
   function automatic logic [CNT_W-1:0] fit_cnt(input logic [31:0] v);
      logic [CNT_W+31:0] w;
      w = {{CNT_W{1'b0}}, v};
      return (|w[CNT_W+31:CNT_W]) ? {CNT_W{1'b1}} : w[CNT_W-1:0];
   endfunction

   // Low 32 bits of a counter, zero filled
   function automatic logic [OUT_W-1:0] to_out(input logic [CNT_W-1:0] c);
      logic [CNT_W+OUT_W-1:0] w;
      w = {{OUT_W{1'b0}}, c};
      return w[OUT_W-1:0];
   endfunction

endpackage

### rtl/pcs_ram.sv
// Generic single-write, single-read memory with registered read data.
module pcs_ram #(
   parameter int ADDR_W = 16,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [DATA_W-1:0] wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [DATA_W-1:0] rdata
);
   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

### rtl/pcs_parse.sv
// Header field capture from the frame byte stream.
module pcs_parse (
   input  logic            clock,
   input  logic            reset,
   input  logic            byte_en,
   input  logic [7:0]      data_byte,
   input  logic            clear,
   output pcs_pkg::hdr_type hdr
);
   import pcs_pkg::*;

   hdr_type    hdr_ff, hdr_in;
   logic [7:0] pos_ff, pos_in;
   logic [7:0] port_pos;

   // Port offset is 14 + 4*IHL
   assign port_pos = POS_VIHL + {2'b00, hdr_ff.ihl, 2'b00};

   // Update fields for the byte at the current position
   always_comb begin
      hdr_in = hdr_ff;
      pos_in = pos_ff;
      if (clear) begin
         hdr_in = '0;
         pos_in = '0;
      end else if (byte_en) begin
         if (pos_ff == POS_ETH_HI) hdr_in.ethertype[15:8] = data_byte;
         if (pos_ff == POS_ETH_LO) begin
            hdr_in.ethertype[7:0] = data_byte;
            hdr_in.have_eth       = 1'b1;
         end
         if (pos_ff == POS_VIHL) begin
            hdr_in.ihl      = data_byte[3:0];
            hdr_in.have_ihl = 1'b1;
         end
         if (pos_ff == POS_PROTO) begin
            hdr_in.proto      = data_byte;
            hdr_in.have_proto = 1'b1;
         end
         if (pos_ff >= POS_SRC_LO && pos_ff <= POS_SRC_HI)
            hdr_in.src_ip = {hdr_ff.src_ip[23:0], data_byte};
         if (pos_ff == POS_SRC_HI) hdr_in.have_src = 1'b1;
         if (pos_ff >= POS_DST_LO && pos_ff <= POS_DST_HI)
            hdr_in.dst_ip = {hdr_ff.dst_ip[23:0], data_byte};
         if (pos_ff == POS_DST_HI) hdr_in.have_dst = 1'b1;
         if (hdr_ff.have_ihl && hdr_ff.ihl >= IHL_MIN) begin
            if (pos_ff == port_pos)         hdr_in.sport[15:8] = data_byte;
            if (pos_ff == port_pos + 8'd1)  hdr_in.sport[7:0]  = data_byte;
            if (pos_ff == port_pos + 8'd2)  hdr_in.dport[15:8] = data_byte;
            if (pos_ff == port_pos + 8'd3) begin
               hdr_in.dport[7:0] = data_byte;
               hdr_in.have_ports = 1'b1;
            end
         end
         if (pos_ff != 8'hFF) pos_in = pos_ff + 8'd1;
         if (hdr_ff.frame_len != 32'hFFFF_FFFF) hdr_in.frame_len = hdr_ff.frame_len + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
         pos_ff <= '0;
      end else begin
         hdr_ff <= hdr_in;
         pos_ff <= pos_in;
      end
   end

   assign hdr = hdr_ff;
endmodule

### rtl/pcs_addr_table.sv
// Address table: slot memories, valid bits and a one-slot-per-cycle search.
module pcs_addr_table (
   input  logic                  clock,
   input  logic                  reset,
   input  pcs_pkg::tbl_cmd_type  cmd,
   output pcs_pkg::tbl_stat_type stat
);
   import pcs_pkg::*;

   logic [31:0]      addr_mem [ADDRESS_SLOTS];
   logic [CNT_W-1:0] src_mem  [ADDRESS_SLOTS];
   logic [CNT_W-1:0] dst_mem  [ADDRESS_SLOTS];
   logic [ADDRESS_SLOTS-1:0] valid_ff;

   tbl_st_type        st_ff, st_in;
   logic [SLOT_W:0]   scan_ff, scan_in;
   logic [SLOT_W-1:0] chk_ff, chk_in;
   logic              chk_v_ff, chk_v_in;
   logic [31:0]       key_ff, key_in;
   logic              is_src_ff, is_src_in;
   logic              hit_ff, hit_in, free_ff, free_in, done_ff, done_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SLOT_W-1:0] raddr;
   logic [31:0]       addr_q_ff;
   logic [CNT_W-1:0]  src_q_ff, dst_q_ff;
   logic              rdv_ff;

   assign raddr = (st_ff == T_SCAN) ? scan_ff[SLOT_W-1:0] : cmd.rd_slot;

   // Read all slot memories at one address
   always_ff @(posedge clock) begin
      addr_q_ff <= addr_mem[raddr];
      src_q_ff  <= src_mem[raddr];
      dst_q_ff  <= dst_mem[raddr];
      rdv_ff    <= valid_ff[raddr];
   end

   // Write a hit count or a new entry
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         if (cmd.wr_new) begin
            addr_mem[slot_ff] <= key_ff;
            src_mem[slot_ff]  <= is_src_ff ? CNT_W'(1) : '0;
            dst_mem[slot_ff]  <= is_src_ff ? '0 : CNT_W'(1);
         end else if (is_src_ff) begin
            src_mem[slot_ff] <= cmd.wr_count;
         end else begin
            dst_mem[slot_ff] <= cmd.wr_count;
         end
      end
   end

   // Issue one slot per cycle, compare the slot read in the previous cycle
   always_comb begin
      st_in     = st_ff;
      scan_in   = scan_ff;
      chk_in    = chk_ff;
      chk_v_in  = 1'b0;
      key_in    = key_ff;
      is_src_in = is_src_ff;
      hit_in    = hit_ff;
      free_in   = free_ff;
      slot_in   = slot_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      case (st_ff)
         T_IDLE: begin
            if (cmd.start) begin
               st_in     = T_SCAN;
               scan_in   = '0;
               key_in    = cmd.key;
               is_src_in = cmd.is_src;
               hit_in    = 1'b0;
               free_in   = 1'b0;
            end
         end
         T_SCAN: begin
            if (scan_ff < (SLOT_W+1)'(ADDRESS_SLOTS)) begin
               chk_in   = scan_ff[SLOT_W-1:0];
               chk_v_in = 1'b1;
               scan_in  = scan_ff + 1'b1;
            end
            if (chk_v_ff) begin
               if (valid_ff[chk_ff] && addr_q_ff == key_ff) begin
                  hit_in   = 1'b1;
                  slot_in  = chk_ff;
                  cnt_in   = is_src_ff ? src_q_ff : dst_q_ff;
                  st_in    = T_IDLE;
                  done_in  = 1'b1;
                  chk_v_in = 1'b0;
               end else begin
                  if (!valid_ff[chk_ff] && !free_ff) begin
                     free_in = 1'b1;
                     slot_in = chk_ff;
                  end
                  if (chk_ff == SLOT_W'(ADDRESS_SLOTS - 1)) begin
                     st_in    = T_IDLE;
                     done_in  = 1'b1;
                     chk_v_in = 1'b0;
                  end
               end
            end
         end
         default: st_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= T_IDLE;
         chk_v_ff <= 1'b0;
         done_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         st_ff    <= st_in;
         chk_v_ff <= chk_v_in;
         done_ff  <= done_in;
         if (cmd.wr_en && cmd.wr_new) valid_ff[slot_ff] <= 1'b1;
      end
      scan_ff   <= scan_in;
      chk_ff    <= chk_in;
      key_ff    <= key_in;
      is_src_ff <= is_src_in;
      hit_ff    <= hit_in;
      free_ff   <= free_in;
      slot_ff   <= slot_in;
      cnt_ff    <= cnt_in;
   end

   always_comb begin
      stat.busy     = (st_ff == T_SCAN);
      stat.done     = done_ff;
      stat.hit      = hit_ff;
      stat.has_free = free_ff;
      stat.count    = cnt_ff;
      stat.rd_valid = rdv_ff;
      stat.rd_addr  = addr_q_ff;
      stat.rd_src   = src_q_ff;
      stat.rd_dst   = dst_q_ff;
   end
endmodule

### rtl/packet_classify_stats.sv
// Top level of the packet classifier: sequencer, shared saturating adder and counters.
// Frame bytes and reads arrive on the req_ stream, one word each; reads answer with one
// rsp_ word. After reset the block clears both port histograms, one entry per cycle, before
// it takes the first word (configuration writes are taken meanwhile). A read passes through
// a wait state before the next word is taken. The byte marked last starts the frame-end
// sequence, which runs all counter updates through one saturating adder and searches the
// address table one slot per cycle. Counters saturate at all ones.
`include "packet_classify_stats_assert.svh"

module packet_classify_stats (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // data_byte [7:0], index [23:8], port_side [24], zero [31:25]
   input  logic [pcs_pkg::REQ_DATA_W-1:0]      req_tdata,
   // kind [1:0]
   input  logic [pcs_pkg::REQ_USER_W-1:0]      req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // result_value [31:0], second_value [63:32], ip_address [95:64]
   output logic [pcs_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // entry_valid [0]
   output logic [pcs_pkg::RSP_USER_W-1:0]      rsp_tuser,
   input  logic                                csr_we,
   input  logic [pcs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pcs_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pcs_pkg::*;

   st_type             state_ff, state_in;
   logic [HIST_W:0]    clr_ff, clr_in;
   logic [PORT_W-1:0]  web_a_ff, web_b_ff;
   logic [1:0]         kind_ff;
   logic [HIST_W-1:0]  idx_ff;
   logic               side_ff, in_range_ff, in_range;
   logic [CNT_W-1:0]   cat_ff [NUM_CAT];
   logic               rsp_valid_ff;
   logic [OUT_W-1:0]   rv_ff, sv_ff, ip_ff, rv_in, sv_in, ip_in;
   logic               ev_ff, ev_in, rsp_load;

   logic               accept, byte_en, parse_clear;
   logic [1:0]         req_kind;
   logic [HIST_W-1:0]  req_index;
   hdr_type            hdr;
   tbl_cmd_type        tbl_cmd;
   tbl_stat_type       tbl_stat;

   logic               cat_we;
   logic [CAT_W-1:0]   cat_wsel, cat_rsel;
   logic [CNT_W-1:0]   cat_q, add_a, add_b, add_sum;

   logic               hs_we, hd_we;
   logic [HIST_W-1:0]  hs_waddr, hd_waddr, hs_raddr, hd_raddr;
   logic [CNT_W-1:0]   hs_wdata, hd_wdata, hs_q, hd_q;

   logic               is_ipv4, eth_en, proto_en, ports_ok, web_hit;
   logic [CAT_W-1:0]   eth_cat, proto_cat;

   assign req_kind  = req_tuser;
   assign req_index = req_tdata[23:8];
   assign accept    = req_tvalid && req_tready;
   assign byte_en   = accept && (req_kind == KIND_BYTE);

   // Classify the captured header
   always_comb begin
      is_ipv4   = hdr.have_eth && hdr.ethertype == ETH_IPV4;
      eth_en    = 1'b1;
      eth_cat   = CAT_IPV4;
      if (!hdr.have_eth)                  eth_en = 1'b0;
      else if (hdr.ethertype == ETH_IPV4) eth_cat = CAT_IPV4;
      else if (hdr.ethertype == ETH_ARP)  eth_cat = CAT_ARP;
      else if (hdr.ethertype == ETH_LLDP) eth_cat = CAT_LLDP;
      else                                eth_en = 1'b0;
      proto_en  = is_ipv4 && hdr.have_proto;
      case (hdr.proto)
         PROTO_TCP:  proto_cat = CAT_TCP;
         PROTO_UDP:  proto_cat = CAT_UDP;
         PROTO_ICMP: proto_cat = CAT_ICMP;
         PROTO_IGMP: proto_cat = CAT_IGMP;
         PROTO_SCTP: proto_cat = CAT_SCTP;
         default: begin
            proto_cat = CAT_SCTP;
            proto_en  = 1'b0;
         end
      endcase
      ports_ok = is_ipv4 && hdr.have_proto && hdr.have_ports &&
                 (hdr.proto == PROTO_TCP || hdr.proto == PROTO_UDP);
      web_hit  = ports_ok && hdr.proto == PROTO_TCP &&
                 (hdr.dport == web_a_ff || hdr.dport == web_b_ff);
   end

   // Range check of a read index
   always_comb begin
      if (req_kind == KIND_CAT)
         in_range = ({1'b0, req_index} < (HIST_W+1)'(NUM_CAT));
      else
         in_range = ({1'b0, req_index} < (HIST_W+1)'(ADDRESS_SLOTS));
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:      if (clr_ff[HIST_W]) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_kind != KIND_BYTE) state_in = ST_RD_WAIT;
               else if (req_tlast)        state_in = ST_FIN_FRAMES;
            end
         end
         ST_RD_WAIT:    state_in = ST_IDLE;
         ST_FIN_FRAMES: state_in = ST_FIN_BYTES;
         ST_FIN_BYTES:  state_in = ST_FIN_ETH;
         ST_FIN_ETH:    state_in = ST_FIN_PROTO;
         ST_FIN_PROTO:  state_in = ST_FIN_WEB;
         ST_FIN_WEB:    state_in = ST_SRC_GO;
         ST_SRC_GO:     state_in = (is_ipv4 && hdr.have_src) ? ST_SRC_WAIT : ST_DST_GO;
         ST_SRC_WAIT:   if (tbl_stat.done) state_in = ST_SRC_UPD;
         ST_SRC_UPD:    state_in = ST_DST_GO;
         ST_DST_GO:     state_in = (is_ipv4 && hdr.have_dst) ? ST_DST_WAIT : ST_HIST_RD;
         ST_DST_WAIT:   if (tbl_stat.done) state_in = ST_DST_UPD;
         ST_DST_UPD:    state_in = ST_HIST_RD;
         ST_HIST_RD:    state_in = ports_ok ? ST_HIST_SRC : ST_FIN_END;
         ST_HIST_SRC:   state_in = ST_HIST_DST;
         ST_HIST_DST:   state_in = ST_FIN_END;
         ST_FIN_END:    state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_tready  = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
      parse_clear = (state_ff == ST_FIN_END);
      clr_in      = clr_ff;
      cat_we      = 1'b0;
      cat_wsel    = CAT_FRAMES;
      add_b       = CNT_W'(1);
      tbl_cmd          = '0;
      tbl_cmd.rd_slot  = req_index[SLOT_W-1:0];
      hs_we = 1'b0;
      hd_we = 1'b0;
      hs_waddr = hdr.sport;
      hd_waddr = hdr.dport;
      hs_wdata = add_sum;
      hd_wdata = add_sum;
      hs_raddr = (state_ff == ST_IDLE) ? req_index : hdr.sport;
      hd_raddr = (state_ff == ST_IDLE) ? req_index : hdr.dport;
      case (state_ff)
         ST_CLEAR: begin
            if (!clr_ff[HIST_W]) begin
               hs_we    = 1'b1;
               hd_we    = 1'b1;
               hs_waddr = clr_ff[HIST_W-1:0];
               hd_waddr = clr_ff[HIST_W-1:0];
               hs_wdata = '0;
               hd_wdata = '0;
               clr_in   = clr_ff + 1'b1;
            end
         end
         ST_FIN_FRAMES: cat_we = 1'b1;
         ST_FIN_BYTES: begin
            cat_we   = 1'b1;
            cat_wsel = CAT_BYTES;
            add_b    = fit_cnt(hdr.frame_len);
         end
         ST_FIN_ETH: begin
            cat_we   = eth_en;
            cat_wsel = eth_cat;
         end
         ST_FIN_PROTO: begin
            cat_we   = proto_en;
            cat_wsel = proto_cat;
         end
         ST_FIN_WEB: begin
            cat_we   = web_hit;
            cat_wsel = CAT_WEB;
         end
         ST_SRC_GO, ST_DST_GO: begin
            tbl_cmd.is_src = (state_ff == ST_SRC_GO);
            tbl_cmd.key    = (state_ff == ST_SRC_GO) ? hdr.src_ip : hdr.dst_ip;
            tbl_cmd.start  = (state_ff == ST_SRC_GO) ? (is_ipv4 && hdr.have_src)
                                                     : (is_ipv4 && hdr.have_dst);
         end
         ST_SRC_UPD, ST_DST_UPD: begin
            tbl_cmd.wr_en    = tbl_stat.hit || tbl_stat.has_free;
            tbl_cmd.wr_new   = !tbl_stat.hit;
            tbl_cmd.wr_count = add_sum;
            cat_we   = !tbl_stat.hit && !tbl_stat.has_free;
            cat_wsel = CAT_DROPS;
         end
         ST_HIST_SRC: hs_we = 1'b1;
         ST_HIST_DST: hd_we = 1'b1;
         default: ;
      endcase
   end

   // Shared saturating adder and its operand selection
   assign cat_rsel = (state_ff == ST_RD_WAIT) ? idx_ff[CAT_W-1:0] : cat_wsel;
   assign cat_q    = cat_ff[cat_rsel];
   always_comb begin
      case (state_ff)
         ST_SRC_UPD, ST_DST_UPD: add_a = tbl_stat.hit ? tbl_stat.count : cat_q;
         ST_HIST_SRC:            add_a = hs_q;
         ST_HIST_DST:            add_a = hd_q;
         default:                add_a = cat_q;
      endcase
   end
   assign add_sum = sat_add(add_a, add_b);

   // Assemble the read result
   always_comb begin
      rsp_load = (state_ff == ST_RD_WAIT);
      rv_in = '0;
      sv_in = '0;
      ip_in = '0;
      ev_in = 1'b0;
      case (kind_ff)
         KIND_CAT:  if (in_range_ff) rv_in = to_out(cat_q);
         KIND_PORT: rv_in = to_out(side_ff ? hd_q : hs_q);
         KIND_SLOT: begin
            if (in_range_ff && tbl_stat.rd_valid) begin
               rv_in = to_out(tbl_stat.rd_src);
               sv_in = to_out(tbl_stat.rd_dst);
               ip_in = tbl_stat.rd_addr;
               ev_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         web_a_ff     <= WEB_A_RST;
         web_b_ff     <= WEB_B_RST;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CAT; i++) cat_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (csr_we && csr_index == REG_WEB_A) web_a_ff <= csr_wdata;
         if (csr_we && csr_index == REG_WEB_B) web_b_ff <= csr_wdata;
         if (rsp_load)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         if (cat_we) cat_ff[cat_wsel] <= add_sum;
      end
      if (accept) begin
         kind_ff     <= req_kind;
         idx_ff      <= req_index;
         side_ff     <= req_tdata[24];
         in_range_ff <= in_range;
      end
      if (rsp_load) begin
         rv_ff <= rv_in;
         sv_ff <= sv_in;
         ip_ff <= ip_in;
         ev_ff <= ev_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {ip_ff, sv_ff, rv_ff};
   assign rsp_tuser  = ev_ff;

   pcs_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .data_byte (req_tdata[7:0]),
      .clear     (parse_clear),
      .hdr       (hdr)
   );

   pcs_addr_table u_table (
      .clock (clock),
      .reset (reset),
      .cmd   (tbl_cmd),
      .stat  (tbl_stat)
   );

   pcs_ram #(.ADDR_W(HIST_W), .DATA_W(CNT_W)) u_src_hist (
      .clock (clock),
      .we    (hs_we),
      .waddr (hs_waddr),
      .wdata (hs_wdata),
      .raddr (hs_raddr),
      .rdata (hs_q)
   );

   pcs_ram #(.ADDR_W(HIST_W), .DATA_W(CNT_W)) u_dst_hist (
      .clock (clock),
      .we    (hd_we),
      .waddr (hd_waddr),
      .wdata (hd_wdata),
      .raddr (hd_raddr),
      .rdata (hd_q)
   );

   // A result is loaded only into an empty output register
   `PCS_ASSERT_SAME(a_rsp_free, state_ff == ST_RD_WAIT, !rsp_valid_ff)
   // The table search is started only while it is idle
   `PCS_ASSERT_SAME(a_tbl_start, tbl_cmd.start, !tbl_stat.busy)
   // Every accepted read word moves the sequencer to the read-wait state in the next cycle
   `PCS_ASSERT_NEXT(a_read_turn, accept && req_kind != KIND_BYTE, state_ff == ST_RD_WAIT)

endmodule
